### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

### hw/rtl/lcdf_pkg.sv
package lcdf_pkg;

   // Display geometry
   localparam int CHARS_PER_LINE = 16;
   localparam int COL_W          = 5;

   // Display commands and characters
   localparam logic [7:0] CMD_LINE1 = 8'h80;
   localparam logic [7:0] CMD_LINE2 = 8'hC0;
   localparam logic [7:0] CH_ESC    = 8'h5C;
   localparam logic [7:0] CH_NL     = 8'h6E;
   localparam logic [7:0] CH_DEG    = 8'h64;
   localparam logic [7:0] CH_LEFT   = 8'h6C;
   localparam logic [7:0] CH_RIGHT  = 8'h72;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Glyph register reset values
   localparam logic [7:0] DEGREE_RST = 8'd223;
   localparam logic [7:0] LEFT_RST   = 8'd127;
   localparam logic [7:0] RIGHT_RST  = 8'd126;

   // Register indexes on the configuration port
   localparam logic [1:0] REG_DEGREE = 2'd0;
   localparam logic [1:0] REG_LEFT   = 2'd1;
   localparam logic [1:0] REG_RIGHT  = 2'd2;

   // Input kinds
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // Decoded work for one item
   localparam logic [1:0] ACT_NONE = 2'd0;
   localparam logic [1:0] ACT_SEND = 2'd1;
   localparam logic [1:0] ACT_NL   = 2'd2;
   localparam logic [1:0] ACT_END  = 2'd3;

   // Byte source for one display write
   localparam logic [1:0] SEL_LINE1 = 2'd0;
   localparam logic [1:0] SEL_LINE2 = 2'd1;
   localparam logic [1:0] SEL_SPACE = 2'd2;
   localparam logic [1:0] SEL_BYTE  = 2'd3;

   typedef struct packed {
      logic       kind;
      logic [7:0] text_char;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [7:0] bus_byte;
      logic       run_last;
   } rsp_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic [1:0] sel;
      logic       last;
      logic       col_inc;
      logic       col_clr;
      logic       set_second;
      logic       end_string;
   } cmd_type;

   typedef struct packed {
      logic       out_free;
      logic       started;
      logic       second;
      logic       col_full;
      logic       col_last;
      logic [1:0] in_act;
      logic [1:0] act;
   } status_type;

endpackage

### hw/rtl/lcd_escape_text_formatter.sv
// Two-line character display formatter: each accepted req_ transaction (a text
// character or an end-of-string mark) produces zero to 2*CHARS_PER_LINE+2 display
// writes on rsp_, the last one flagged by run_last. Backslash escapes select a
// newline or one of three glyph codes held in registers at byte addresses 0, 4 and 8
// of the APB port. One item is processed at a time: the block accepts an item while
// idle and then issues one display write per cycle while the output register is
// free, and padding runs after a newline or end mark hold the input for up to
// 2*CHARS_PER_LINE+2 writes. The single output register sets this pace; a stalled
// rsp_ready stalls the write sequencer, while a finished result may wait in the
// output register as the next item is taken.
module lcd_escape_text_formatter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcdf_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcdf_pkg::rsp_type rsp_payload,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   lcdf_pkg::cmd_type    cmd;
   lcdf_pkg::status_type status;

   assign pready = 1'b1;

   // Write sequencer
   lcdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // String state, glyph registers and output register
   lcdf_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

### hw/rtl/lcdf_datapath.sv
module lcdf_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lcdf_pkg::req_type    req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output lcdf_pkg::rsp_type    rsp_payload,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   input  lcdf_pkg::cmd_type    cmd,
   output lcdf_pkg::status_type status
);

   logic [7:0]                  degree_ff, degree_in;
   logic [7:0]                  left_ff, left_in;
   logic [7:0]                  right_ff, right_in;
   logic                        started_ff, started_in;
   logic                        esc_ff, esc_in;
   logic                        second_ff, second_in;
   logic [lcdf_pkg::COL_W-1:0]  col_ff, col_in;
   logic [1:0]                  act_ff, act_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   lcdf_pkg::rsp_type           rsp_ff, rsp_in;
   logic                        eff_esc;
   logic                        eff_second;
   logic [1:0]                  in_act;
   logic [7:0]                  in_byte;
   logic                        csr_write;

   // Write glyph registers
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      degree_in = degree_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      if (csr_write) begin
         case (paddr[3:2])
            lcdf_pkg::REG_DEGREE: degree_in = pwdata[7:0];
            lcdf_pkg::REG_LEFT:   left_in   = pwdata[7:0];
            lcdf_pkg::REG_RIGHT:  right_in  = pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Read back glyph registers
   always_comb begin
      case (paddr[3:2])
         lcdf_pkg::REG_DEGREE: prdata = {24'd0, degree_ff};
         lcdf_pkg::REG_LEFT:   prdata = {24'd0, left_ff};
         lcdf_pkg::REG_RIGHT:  prdata = {24'd0, right_ff};
         default:              prdata = 32'd0;
      endcase
   end

   // Decode the incoming item against the state it will see
   assign eff_esc    = started_ff & esc_ff;
   assign eff_second = started_ff & second_ff;

   always_comb begin
      in_act  = lcdf_pkg::ACT_NONE;
      in_byte = req_payload.text_char;
      if (req_payload.kind == lcdf_pkg::KIND_END) begin
         in_act = lcdf_pkg::ACT_END;
      end else if (eff_esc) begin
         case (req_payload.text_char)
            lcdf_pkg::CH_NL:    in_act = lcdf_pkg::ACT_NL;
            lcdf_pkg::CH_DEG: begin
               in_act  = lcdf_pkg::ACT_SEND;
               in_byte = degree_ff;
            end
            lcdf_pkg::CH_LEFT: begin
               in_act  = lcdf_pkg::ACT_SEND;
               in_byte = left_ff;
            end
            lcdf_pkg::CH_RIGHT: begin
               in_act  = lcdf_pkg::ACT_SEND;
               in_byte = right_ff;
            end
            default:            in_act = lcdf_pkg::ACT_NONE;
         endcase
      end else if (req_payload.text_char != lcdf_pkg::CH_ESC) begin
         in_act = lcdf_pkg::ACT_SEND;
      end
   end

   // Update string state
   always_comb begin
      started_in = started_ff;
      esc_in     = esc_ff;
      second_in  = second_ff;
      col_in     = col_ff;
      act_in     = act_ff;
      byte_in    = byte_ff;
      if (cmd.load) begin
         started_in = 1'b1;
         esc_in     = (req_payload.kind == lcdf_pkg::KIND_CHAR) && !eff_esc &&
                      (req_payload.text_char == lcdf_pkg::CH_ESC);
         second_in  = eff_second;
         col_in     = started_ff ? col_ff : '0;
         act_in     = in_act;
         byte_in    = in_byte;
      end
      if (cmd.emit) begin
         if (cmd.col_clr) begin
            col_in = '0;
         end else if (cmd.col_inc) begin
            col_in = col_ff + 1'b1;
         end
         if (cmd.set_second) begin
            second_in = 1'b1;
         end
      end
      if (cmd.end_string) begin
         started_in = 1'b0;
         esc_in     = 1'b0;
         second_in  = 1'b0;
         col_in     = '0;
      end
   end

   // Output register: hold until the transaction completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (cmd.emit) begin
         rsp_valid_in     = 1'b1;
         rsp_in.run_last  = cmd.last;
         case (cmd.sel)
            lcdf_pkg::SEL_LINE1: begin
               rsp_in.reg_select = 1'b0;
               rsp_in.bus_byte   = lcdf_pkg::CMD_LINE1;
            end
            lcdf_pkg::SEL_LINE2: begin
               rsp_in.reg_select = 1'b0;
               rsp_in.bus_byte   = lcdf_pkg::CMD_LINE2;
            end
            lcdf_pkg::SEL_SPACE: begin
               rsp_in.reg_select = 1'b1;
               rsp_in.bus_byte   = lcdf_pkg::CH_SPACE;
            end
            default: begin
               rsp_in.reg_select = 1'b1;
               rsp_in.bus_byte   = byte_ff;
            end
         endcase
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff    <= lcdf_pkg::DEGREE_RST;
         left_ff      <= lcdf_pkg::LEFT_RST;
         right_ff     <= lcdf_pkg::RIGHT_RST;
         started_ff   <= 1'b0;
         esc_ff       <= 1'b0;
         second_ff    <= 1'b0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         degree_ff    <= degree_in;
         left_ff      <= left_in;
         right_ff     <= right_in;
         started_ff   <= started_in;
         esc_ff       <= esc_in;
         second_ff    <= second_in;
         col_ff       <= col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff  <= act_in;
      byte_ff <= byte_in;
      rsp_ff  <= rsp_in;
   end

   // Status back to the controller
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.started  = started_ff;
   assign status.second   = second_ff;
   assign status.col_full = col_ff >= lcdf_pkg::COL_W'(lcdf_pkg::CHARS_PER_LINE);
   assign status.col_last = col_ff == lcdf_pkg::COL_W'(lcdf_pkg::CHARS_PER_LINE - 1);
   assign status.in_act   = in_act;
   assign status.act      = act_ff;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### hw/rtl/lcdf_ctrl.sv
`include "assert_macros.svh"

module lcdf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lcdf_pkg::status_type status,
   output lcdf_pkg::cmd_type    cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_HEAD = 3'd1;
   localparam logic [2:0] S_PAD  = 3'd2;
   localparam logic [2:0] S_CMD2 = 3'd3;
   localparam logic [2:0] S_SEND = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [2:0] after;

   // Pick the first write state for a decoded item
   function automatic logic [2:0] dispatch(logic [1:0] act, logic col_full, logic second);
      logic [2:0] nxt;
      nxt = S_IDLE;
      case (act)
         lcdf_pkg::ACT_END: begin
            if (!col_full) begin
               nxt = S_PAD;
            end else if (!second) begin
               nxt = S_CMD2;
            end
         end
         lcdf_pkg::ACT_NL: begin
            if (!second) begin
               nxt = col_full ? S_CMD2 : S_PAD;
            end
         end
         lcdf_pkg::ACT_SEND: nxt = col_full ? S_IDLE : S_SEND;
         default:            nxt = S_IDLE;
      endcase
      return nxt;
   endfunction

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      after    = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.started ?
                          dispatch(status.in_act, status.col_full, status.second) : S_HEAD;
               cmd.end_string = status.started && (state_in == S_IDLE) &&
                                (status.in_act == lcdf_pkg::ACT_END);
            end
         end
         S_HEAD: begin
            cmd.sel = lcdf_pkg::SEL_LINE1;
            after   = dispatch(status.act, status.col_full, status.second);
         end
         S_PAD: begin
            cmd.sel     = lcdf_pkg::SEL_SPACE;
            cmd.col_inc = 1'b1;
            if (status.col_last) begin
               after = (status.act == lcdf_pkg::ACT_END && status.second) ? S_IDLE : S_CMD2;
            end else begin
               after = S_PAD;
            end
         end
         S_CMD2: begin
            cmd.sel        = lcdf_pkg::SEL_LINE2;
            cmd.col_clr    = 1'b1;
            cmd.set_second = 1'b1;
            after          = (status.act == lcdf_pkg::ACT_END) ? S_PAD : S_IDLE;
         end
         S_SEND: begin
            cmd.sel     = lcdf_pkg::SEL_BYTE;
            cmd.col_inc = 1'b1;
            after       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Emit one write when the output register frees up
      if (state_ff != S_IDLE && state_ff <= S_SEND && status.out_free) begin
         cmd.emit       = 1'b1;
         cmd.last       = (after == S_IDLE);
         cmd.end_string = (after == S_IDLE) && (status.act == lcdf_pkg::ACT_END);
         state_in       = after;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   `ASSERT_CLK(a_emit_needs_room, clock, reset, cmd.emit |-> status.out_free)
   `ASSERT_CLK(a_busy_in_string, clock, reset, (state_ff != S_IDLE) |-> status.started)
   `ASSERT_NEVER(a_pad_past_line, clock, reset,
                 (state_ff == S_PAD || state_ff == S_SEND) && status.col_full)
   `ASSERT_NEVER(a_line2_twice, clock, reset, (state_ff == S_CMD2) && status.second)

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import lcdf_pkg::*;

   localparam logic RS_CMD  = 1'b0;
   localparam logic RS_DATA = 1'b1;

   localparam logic [3:0] UNUSED_ADDR = 4'hC;

   localparam int SETTLE_CYCLES = 2 * CHARS_PER_LINE + 8;
   localparam int QUIET_LIMIT   = 3000;
   localparam int PHASE_ITEMS   = 95;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_payload;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [3:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   // Stimulus feed and expected display writes
   req_type feed_q[$];
   rsp_type lcd_writes_q[$];
   rsp_type item_writes[$];
   int      items_queued;
   int      items_accepted;
   int      fail_count;
   int      quiet_cycles;
   int      send_idle_pct;
   int      recv_stall_pct;
   logic    req_done;

   // Formatter shadow state and glyph registers
   logic             str_open;
   logic             esc_armed;
   logic             on_line2;
   logic [COL_W-1:0] col;
   logic [7:0]       degree_glyph;
   logic [7:0]       left_glyph;
   logic [7:0]       right_glyph;

   lcd_escape_text_formatter u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #10 clock = ~clock;

   function automatic void log_failure(string text);
      fail_count++;
      if (fail_count <= 10) begin
         $display("%s", text);
      end
   endfunction

   function automatic void emit(logic rs, logic [7:0] value);
      rsp_type w;
      w.reg_select = rs;
      w.bus_byte   = value;
      w.run_last   = 1'b0;
      item_writes.push_back(w);
   endfunction

   function automatic void pad_line();
      while (col < CHARS_PER_LINE) begin
         emit(RS_DATA, CH_SPACE);
         col++;
      end
   endfunction

   function automatic void put_char(logic [7:0] value);
      if (col < CHARS_PER_LINE) begin
         emit(RS_DATA, value);
         col++;
      end
   endfunction

   // Work out the display writes one text item causes
   function automatic void format_item(req_type item);
      item_writes.delete();
      if (!str_open) begin
         emit(RS_CMD, CMD_LINE1);
         str_open  = 1'b1;
         on_line2  = 1'b0;
         col       = '0;
         esc_armed = 1'b0;
      end
      if (item.kind == KIND_END) begin
         pad_line();
         if (!on_line2) begin
            emit(RS_CMD, CMD_LINE2);
            col = '0;
            pad_line();
         end
         str_open  = 1'b0;
         esc_armed = 1'b0;
         on_line2  = 1'b0;
         col       = '0;
      end else if (esc_armed) begin
         esc_armed = 1'b0;
         case (item.text_char)
            CH_NL: begin
               if (!on_line2) begin
                  pad_line();
                  emit(RS_CMD, CMD_LINE2);
                  on_line2 = 1'b1;
                  col      = '0;
               end
            end
            CH_DEG:   put_char(degree_glyph);
            CH_LEFT:  put_char(left_glyph);
            CH_RIGHT: put_char(right_glyph);
            default: ;
         endcase
      end else if (item.text_char == CH_ESC) begin
         esc_armed = 1'b1;
      end else begin
         put_char(item.text_char);
      end
      if (item_writes.size() != 0) begin
         item_writes[$].run_last = 1'b1;
      end
      foreach (item_writes[k]) begin
         lcd_writes_q.push_back(item_writes[k]);
      end
   endfunction

   function automatic void push_item(logic kind, logic [7:0] value);
      req_type item;
      item.kind      = kind;
      item.text_char = value;
      feed_q.push_back(item);
      items_queued++;
   endfunction

   // Queue a string of random text with escapes; some are left open or broken
   task automatic queue_string();
      int n_chars;
      int pick;
      n_chars = ($urandom_range(7) == 0) ? $urandom_range(24, 14) : $urandom_range(12);
      for (int k = 0; k < n_chars; k++) begin
         pick = $urandom_range(99);
         if (pick < 25) begin
            push_item(KIND_CHAR, CH_ESC);
            case ($urandom_range(5))
               0: push_item(KIND_CHAR, CH_NL);
               1: push_item(KIND_CHAR, CH_DEG);
               2: push_item(KIND_CHAR, CH_LEFT);
               3: push_item(KIND_CHAR, CH_RIGHT);
               4: push_item(KIND_CHAR, CH_ESC);
               default: push_item(KIND_CHAR, 8'($urandom_range(255)));
            endcase
         end else if (pick < 30) begin
            push_item(KIND_CHAR, CH_NL);
         end else begin
            push_item(KIND_CHAR, 8'($urandom_range(255)));
         end
      end
      pick = $urandom_range(99);
      if (pick < 8) begin
         push_item(KIND_CHAR, CH_ESC);
      end
      if (pick >= 4) begin
         push_item(KIND_END, 8'($urandom_range(255)));
      end
   endtask

   task automatic csr_access(input logic wr, input logic [3:0] addr, input logic [31:0] data,
                             output logic [31:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [7:0] value);
      logic [31:0] unused;
      csr_access(1'b1, addr, {8'($urandom_range(255)), 16'($urandom_range(65535)), value},
                 unused);
      case (addr)
         {REG_DEGREE, 2'b00}: degree_glyph = value;
         {REG_LEFT, 2'b00}:   left_glyph   = value;
         {REG_RIGHT, 2'b00}:  right_glyph  = value;
         default: ;
      endcase
   endtask

   task automatic csr_check(input logic [1:0] idx, input logic [7:0] want);
      logic [31:0] got;
      csr_access(1'b0, {idx, 2'b00}, '0, got);
      if (got[7:0] !== want) begin
         log_failure($sformatf("register %0d readback: expected %02h, got %02h",
                               idx, want, got[7:0]));
      end
   endtask

   task automatic check_glyphs();
      csr_check(REG_DEGREE, degree_glyph);
      csr_check(REG_LEFT, left_glyph);
      csr_check(REG_RIGHT, right_glyph);
   endtask

   // Hold until every item is taken and every write has come back
   task automatic wait_drained();
      while (items_accepted != items_queued || lcd_writes_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Drive the request channel from the feed queue
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_done) begin
         if (feed_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_payload <= feed_q.pop_front();
            req_valid   <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Stall the response channel at random
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_stall_pct);
   end

   // Predict on each request transaction, check each response transaction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_done     <= 1'b0;
         str_open     = 1'b0;
         esc_armed    = 1'b0;
         on_line2     = 1'b0;
         col          = '0;
         degree_glyph = DEGREE_RST;
         left_glyph   = LEFT_RST;
         right_glyph  = RIGHT_RST;
      end else begin
         req_done <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            format_item(req_payload);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (lcd_writes_q.size() == 0) begin
               log_failure($sformatf("unexpected write: rs=%0d byte=%02h last=%0d",
                                     rsp_payload.reg_select, rsp_payload.bus_byte,
                                     rsp_payload.run_last));
            end else begin
               want = lcd_writes_q.pop_front();
               if (rsp_payload.reg_select !== want.reg_select ||
                   rsp_payload.bus_byte !== want.bus_byte ||
                   rsp_payload.run_last !== want.run_last) begin
                  log_failure($sformatf(
                     "write mismatch: expected rs=%0d byte=%02h last=%0d, got rs=%0d byte=%02h last=%0d",
                     want.reg_select, want.bus_byte, want.run_last,
                     rsp_payload.reg_select, rsp_payload.bus_byte, rsp_payload.run_last));
               end
            end
         end
      end
   end

   // Watchdog: drop out when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_start;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_payload    = '0;
      rsp_ready      = 1'b0;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      items_queued   = 0;
      items_accepted = 0;
      fail_count     = 0;
      quiet_cycles   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 4; phase++) begin
         phase_start = items_queued;
         case (phase)
            0: begin
               send_idle_pct  = 0;
               recv_stall_pct = 0;
               check_glyphs();
               // Empty string, byte extremes, every escape, newline on line 2,
               // trailing backslash
               push_item(KIND_END, 8'hFF);
               push_item(KIND_CHAR, 8'h00);
               push_item(KIND_CHAR, 8'hFF);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_DEG);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_LEFT);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_RIGHT);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, "q");
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_NL);
               push_item(KIND_CHAR, "A");
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_CHAR, CH_NL);
               push_item(KIND_CHAR, CH_ESC);
               push_item(KIND_END, 8'h00);
               push_item(KIND_CHAR, "Z");
               push_item(KIND_END, 8'h5A);
            end
            1: begin
               send_idle_pct  = 80;
               recv_stall_pct = 0;
               csr_write({REG_DEGREE, 2'b00}, 8'h00);
               csr_write({REG_LEFT, 2'b00}, 8'hFF);
               csr_write({REG_RIGHT, 2'b00}, CH_ESC);
               csr_write(UNUSED_ADDR, 8'($urandom_range(255)));
               check_glyphs();
            end
            2: begin
               send_idle_pct  = 0;
               recv_stall_pct = 80;
               csr_write({REG_DEGREE, 2'b00}, CH_ESC);
               csr_write({REG_LEFT, 2'b00}, 8'h00);
               csr_write({REG_RIGHT, 2'b00}, 8'hFF);
               check_glyphs();
            end
            default: begin
               send_idle_pct  = 34;
               recv_stall_pct = 34;
               csr_write({REG_DEGREE, 2'b00}, 8'($urandom_range(255)));
               csr_write({REG_LEFT, 2'b00}, 8'($urandom_range(255)));
               csr_write({REG_RIGHT, 2'b00}, 8'($urandom_range(255)));
               check_glyphs();
            end
         endcase
         while (items_queued - phase_start < PHASE_ITEMS) begin
            queue_string();
         end
         wait_drained();
      end

      if (fail_count == 0 && lcd_writes_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
